/* rtl/core/vcb_pkg.sv */
// ----------------------------------------------------------------------------
// vcb_pkg
// Shared constants and types for the vertex cache batcher.
// ----------------------------------------------------------------------------
`default_nettype none

package vcb_pkg;

  // Default sizes handed to the top level
  localparam int CACHE_DEPTH_DEF = 64;
  localparam int INDEX_BITS_DEF  = 16;

  // Indices carried by one face
  localparam int NUM_KEYS = 3;

  // Cache size register
  localparam int             CFG_W          = 7;
  localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 7'd32;
  localparam int             MIN_CACHE      = 3;

  // Write control from the batch logic into the lookup array
  typedef struct packed {
    logic                clear;   // drop every entry this cycle
    logic [NUM_KEYS-1:0] wr_en;   // load key k into its slot
  } vcb_cam_wr_t;

endpackage

`default_nettype wire

/* rtl/core/vcb_cam.sv */
// ----------------------------------------------------------------------------
// vcb_cam
// Associative lookup array: source indices with valid bits, three parallel
// key compares and up to three slot writes per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vcb_cam #(
  parameter int CACHE_DEPTH = vcb_pkg::CACHE_DEPTH_DEF,
  parameter int INDEX_BITS  = vcb_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic [vcb_pkg::NUM_KEYS-1:0][INDEX_BITS-1:0]   key,
  input  wire vcb_pkg::vcb_cam_wr_t                           wr,
  input  wire logic [vcb_pkg::NUM_KEYS-1:0][$clog2(CACHE_DEPTH)-1:0] wr_slot,
  output logic      [vcb_pkg::NUM_KEYS-1:0]                   hit,
  output logic      [vcb_pkg::NUM_KEYS-1:0][$clog2(CACHE_DEPTH)-1:0] hit_slot
);

  localparam int IDX_W = $clog2(CACHE_DEPTH);

  logic [INDEX_BITS-1:0]  src_r [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid_r;
  logic [CACHE_DEPTH-1:0] valid_nxt;

  // Compare every key against every live entry; entries hold no duplicates
  always_comb begin
    hit      = '0;
    hit_slot = '0;
    for (int k = 0; k < vcb_pkg::NUM_KEYS; k++) begin
      for (int e = 0; e < CACHE_DEPTH; e++) begin
        if (valid_r[e] && (src_r[e] == key[k])) begin
          hit[k]      = 1'b1;
          hit_slot[k] = hit_slot[k] | IDX_W'(e);
        end
      end
    end
  end

  // Valid bits: clear and fresh writes land in the same cycle
  always_comb begin
    valid_nxt = wr.clear ? '0 : valid_r;
    for (int k = 0; k < vcb_pkg::NUM_KEYS; k++) begin
      for (int e = 0; e < CACHE_DEPTH; e++) begin
        if (wr.wr_en[k] && (wr_slot[k] == IDX_W'(e))) begin
          valid_nxt[e] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Source storage, no reset needed
  always_ff @(posedge clk) begin
    for (int k = 0; k < vcb_pkg::NUM_KEYS; k++) begin
      for (int e = 0; e < CACHE_DEPTH; e++) begin
        if (wr.wr_en[k] && (wr_slot[k] == IDX_W'(e))) begin
          src_r[e] <= key[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vertex_cache_batcher_core.sv */
// ----------------------------------------------------------------------------
// vertex_cache_batcher_core
// Remaps a stream of faces onto a small vertex cache, flushing the cache
// when the face's new vertices would not fit or a new chunk starts.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the lookup/insert logic into the result
//   register.
// Throughput: one face per cycle unless the result stalls; the cache state
//   updates in the same cycle that a face moves into the result register.
// Reset (synchronous, rst_n low): cache emptied, output counter zero,
//   cache size register back to 32, both stages empty.
`default_nettype none

module vertex_cache_batcher_core #(
  parameter int CACHE_DEPTH = vcb_pkg::CACHE_DEPTH_DEF,
  parameter int INDEX_BITS  = vcb_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // in_tdata: index_count[2], vertex_index_0, vertex_index_1, vertex_index_2
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((2+3*INDEX_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: new_chunk
  input  wire logic                                    in_tuser,
  // out_tdata: out_index_0..2, loaded_count[2], loaded_source_0..2
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((2+6*INDEX_BITS+7)/8)*8-1:0]     out_tdata,
  // out_tuser: flushed, counter_overflow
  output logic      [1:0]                              out_tuser,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [vcb_pkg::CFG_W-1:0]               cfg_data
);

  localparam int NK         = vcb_pkg::NUM_KEYS;
  localparam int IN_DATA_W  = ((2+3*INDEX_BITS+7)/8)*8;
  localparam int OUT_DATA_W = ((2+6*INDEX_BITS+7)/8)*8;
  localparam int IDX_W      = $clog2(CACHE_DEPTH);
  localparam int OCC_W      = $clog2(CACHE_DEPTH+1);
  localparam int NUM_W      = INDEX_BITS + 1;
  localparam int SUM_W      = NUM_W + 1;
  localparam int CW         = ((OCC_W > vcb_pkg::CFG_W) ? OCC_W : vcb_pkg::CFG_W) + 1;
  localparam logic [SUM_W-1:0] CNT_LIMIT = {{(SUM_W-1){1'b0}}, 1'b1} << INDEX_BITS;

  // Saturate a number to the index range
  function automatic logic [INDEX_BITS-1:0] sat_num(input logic [SUM_W-1:0] v);
    logic [INDEX_BITS-1:0] r;
    r = (v >= CNT_LIMIT) ? {INDEX_BITS{1'b1}} : v[INDEX_BITS-1:0];
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [vcb_pkg::CFG_W-1:0] cfg_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= vcb_pkg::CACHE_SIZE_RST;
    end else if (cfg_valid) begin
      cfg_size_r <= cfg_data;
    end
  end

  // ---------------- input register ----------------
  logic                              s1_v_r;
  logic                              s1_nc_r;
  logic [1:0]                        s1_cnt_r;
  logic [NK-1:0][INDEX_BITS-1:0]     s1_key_r;
  logic                              fire;
  logic                              out_v_r;

  assign fire      = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_nc_r  <= in_tuser;
      s1_cnt_r <= in_tdata[1:0];
      for (int k = 0; k < NK; k++) begin
        s1_key_r[k] <= in_tdata[2 + k*INDEX_BITS +: INDEX_BITS];
      end
    end
  end

  // ---------------- cache state ----------------
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [NUM_W-1:0] next_r, next_nxt;
  logic [NUM_W-1:0] base_r, base_nxt;

  vcb_pkg::vcb_cam_wr_t           cam_wr;
  logic [NK-1:0][IDX_W-1:0]       wr_slot;
  logic [NK-1:0]                  cam_hit;
  logic [NK-1:0][IDX_W-1:0]       cam_slot;

  vcb_cam #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_cam (
    .clk      (clk),
    .rst_n    (rst_n),
    .key      (s1_key_r),
    .wr       (cam_wr),
    .wr_slot  (wr_slot),
    .hit      (cam_hit),
    .hit_slot (cam_slot)
  );

  // ---------------- lookup, flush and insert ----------------
  logic [NK-1:0]             pos_on, hit, miss, keep, fresh, ins;
  logic [1:0]                needed, loaded;
  logic [1:0]                rank1, rank2, rk1, rk2;
  logic [OCC_W-1:0]          occ_eff, occ2, slot0, slot1, slot2;
  logic [NUM_W-1:0]          next_eff;
  logic [CW-1:0]             cfg_ext, cap;
  logic                      flush;
  logic                      eq01, eq02, eq12;
  logic [SUM_W-1:0]          next_sum;
  logic [NK-1:0][INDEX_BITS-1:0] remap;
  logic [NK-1:0][1:0]        rk;
  logic [INDEX_BITS-1:0]     lsrc0, lsrc1, lsrc2;

  // Effective cache size, clamped to what any face needs and the array holds
  always_comb begin
    cfg_ext = CW'(cfg_size_r);
    if (cfg_ext < CW'(vcb_pkg::MIN_CACHE)) begin
      cap = CW'(vcb_pkg::MIN_CACHE);
    end else if (cfg_ext > CW'(CACHE_DEPTH)) begin
      cap = CW'(CACHE_DEPTH);
    end else begin
      cap = cfg_ext;
    end
  end

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      pos_on[k] = (s1_cnt_r > 2'(k));
      hit[k]    = pos_on[k] && cam_hit[k] && !s1_nc_r;
      miss[k]   = pos_on[k] && !hit[k];
    end
    occ_eff  = s1_nc_r ? '0 : occ_r;
    next_eff = s1_nc_r ? '0 : next_r;
    // Each miss counts toward the flush compare, repeated indices included
    needed   = {1'b0, miss[0]} + {1'b0, miss[1]} + {1'b0, miss[2]};
    flush    = (CW'(needed) + CW'(occ_eff)) > cap;
    occ2     = flush ? '0 : occ_eff;

    for (int k = 0; k < NK; k++) begin
      keep[k]  = hit[k] && !flush;
      fresh[k] = pos_on[k] && !keep[k];
    end

    // A repeated new index is inserted once, at its first position
    eq01   = (s1_key_r[0] == s1_key_r[1]);
    eq02   = (s1_key_r[0] == s1_key_r[2]);
    eq12   = (s1_key_r[1] == s1_key_r[2]);
    ins[0] = fresh[0];
    ins[1] = fresh[1] && !(fresh[0] && eq01);
    ins[2] = fresh[2] && !(fresh[0] && eq02) && !(fresh[1] && eq12);

    rank1  = {1'b0, ins[0]};
    rank2  = {1'b0, ins[0]} + {1'b0, ins[1]};
    loaded = rank2 + {1'b0, ins[2]};

    // Insertion rank that supplies each position's number
    rk1 = (fresh[0] && eq01) ? 2'd0 : rank1;
    rk2 = (fresh[0] && eq02) ? 2'd0 : ((fresh[1] && eq12) ? rk1 : rank2);
    rk[0] = 2'd0;
    rk[1] = rk1;
    rk[2] = rk2;

    slot0 = occ2;
    slot1 = occ2 + OCC_W'(rank1);
    slot2 = occ2 + OCC_W'(rank2);

    // Slot k of the current map holds number base + k
    for (int k = 0; k < NK; k++) begin
      if (!pos_on[k]) begin
        remap[k] = '0;
      end else if (keep[k]) begin
        remap[k] = sat_num(SUM_W'(base_r) + SUM_W'(cam_slot[k]));
      end else begin
        remap[k] = sat_num(SUM_W'(next_eff) + SUM_W'(rk[k]));
      end
    end

    // Newly loaded sources in insertion order
    lsrc0 = ins[0] ? s1_key_r[0] : (ins[1] ? s1_key_r[1] : (ins[2] ? s1_key_r[2] : '0));
    if (ins[0] && ins[1]) begin
      lsrc1 = s1_key_r[1];
    end else if ((ins[0] ^ ins[1]) && ins[2]) begin
      lsrc1 = s1_key_r[2];
    end else begin
      lsrc1 = '0;
    end
    lsrc2 = (ins == 3'b111) ? s1_key_r[2] : '0;

    next_sum = SUM_W'(next_eff) + SUM_W'(loaded);
    next_nxt = (next_sum >= CNT_LIMIT) ? NUM_W'(CNT_LIMIT) : next_sum[NUM_W-1:0];
    occ_nxt  = occ2 + OCC_W'(loaded);
    base_nxt = (occ2 == '0) ? next_eff : base_r;
  end

  assign cam_wr.clear = fire && (s1_nc_r || flush);
  assign cam_wr.wr_en = fire ? ins : '0;
  assign wr_slot[0]   = slot0[IDX_W-1:0];
  assign wr_slot[1]   = slot1[IDX_W-1:0];
  assign wr_slot[2]   = slot2[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      next_r <= '0;
      base_r <= '0;
    end else if (fire) begin
      occ_r  <= occ_nxt;
      next_r <= next_nxt;
      base_r <= base_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r;

  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < NK; k++) begin
      out_data_nxt[k*INDEX_BITS +: INDEX_BITS] = remap[k];
    end
    out_data_nxt[NK*INDEX_BITS +: 2]                  = loaded;
    out_data_nxt[NK*INDEX_BITS + 2 +: INDEX_BITS]     = lsrc0;
    out_data_nxt[(NK+1)*INDEX_BITS + 2 +: INDEX_BITS] = lsrc1;
    out_data_nxt[(NK+2)*INDEX_BITS + 2 +: INDEX_BITS] = lsrc2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {next_nxt[INDEX_BITS], flush};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

/* rtl/core/vcb_checker.sv */
// ----------------------------------------------------------------------------
// vcb_checker
// Port-level checks for the vertex cache batcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcb_checker #(
  parameter int INDEX_BITS = vcb_pkg::INDEX_BITS_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [((2+6*INDEX_BITS+7)/8)*8-1:0] out_tdata,
  input wire logic [1:0]                          out_tuser
);

  localparam int LC_LO = 3*INDEX_BITS;

  logic [1:0]            lc;
  logic [INDEX_BITS-1:0] ls0, ls1, ls2;

  assign lc  = out_tdata[LC_LO +: 2];
  assign ls0 = out_tdata[LC_LO + 2 +: INDEX_BITS];
  assign ls1 = out_tdata[LC_LO + 2 + INDEX_BITS +: INDEX_BITS];
  assign ls2 = out_tdata[LC_LO + 2 + 2*INDEX_BITS +: INDEX_BITS];

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // With the result stage empty the input side never stalls
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // Loaded source slots beyond loaded_count read zero
  a_loaded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((lc != 2'd0) || (ls0 == '0)) && ((lc == 2'd2) || (lc == 2'd3) || (ls1 == '0))
                   && ((lc == 2'd3) || (ls2 == '0)))
    else $error("loaded source beyond loaded_count");

  // Reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind vertex_cache_batcher_core vcb_checker #(.INDEX_BITS(INDEX_BITS)) u_vcb_checker (.*);

`default_nettype wire
